// ----- hw/rtl/wer_pkg.sv -----
// ----------------------------------------------------------------------------
// wer_pkg
// Shared widths, register indexes, command codes and status bundle for the
// weight-elimination regularizer.
// ----------------------------------------------------------------------------
package wer_pkg;

    localparam int FAN_IN_MAX_DEF = 4095;

    localparam int DATA_W     = 32;
    localparam int W0_W       = 31;
    localparam int FAN_IN_W   = 12;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_W0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_IN   = 2'd3;

    // Datapath commands
    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_NONE        = 4'd0;
    localparam cmd_t CMD_LOAD        = 4'd1;
    localparam cmd_t CMD_MUL_W2      = 4'd2;
    localparam cmd_t CMD_MUL_S       = 4'd3;
    localparam cmd_t CMD_DSUM        = 4'd4;
    localparam cmd_t CMD_DIV_P_START = 4'd5;
    localparam cmd_t CMD_DIV_R_START = 4'd6;
    localparam cmd_t CMD_DIV_Q_START = 4'd7;
    localparam cmd_t CMD_DIV_STEP    = 4'd8;
    localparam cmd_t CMD_MUL_M       = 4'd9;
    localparam cmd_t CMD_MUL_LO      = 4'd10;
    localparam cmd_t CMD_MUL_HI      = 4'd11;
    localparam cmd_t CMD_COMB        = 4'd12;
    localparam cmd_t CMD_FIN         = 4'd13;

    typedef struct packed {
        logic d_zero;
        logic apply_term;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/wer_if.sv -----
// ----------------------------------------------------------------------------
// wer_if
// Valid/ready channels for weight requests and regularized results.
// ----------------------------------------------------------------------------
interface wer_in_if;
    import wer_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] gradient;
    logic                     last_weight;

    modport source (output valid, weight, gradient, last_weight, input ready);
    modport sink   (input valid, weight, gradient, last_weight, output ready);
endinterface

interface wer_out_if;
    import wer_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_gradient;
    logic [ACC_W-1:0]         penalty_sum;
    logic                     is_last;

    modport source (output valid, new_gradient, penalty_sum, is_last, input ready);
    modport sink   (input valid, new_gradient, penalty_sum, is_last, output ready);
endinterface

// ----- hw/rtl/wer_ctrl.sv -----
// ----------------------------------------------------------------------------
// wer_ctrl
// Sequencer: steps the datapath through squares, up to three divisions and,
// when the term is applied, the alpha product for one request.
// ----------------------------------------------------------------------------
module wer_ctrl
    import wer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_W2      = 4'd1;
    localparam logic [3:0] S_S       = 4'd2;
    localparam logic [3:0] S_DSUM    = 4'd3;
    localparam logic [3:0] S_DIVP_LD = 4'd4;
    localparam logic [3:0] S_DIVP    = 4'd5;
    localparam logic [3:0] S_DIVR_LD = 4'd6;
    localparam logic [3:0] S_DIVR    = 4'd7;
    localparam logic [3:0] S_MULM    = 4'd8;
    localparam logic [3:0] S_DIVQ_LD = 4'd9;
    localparam logic [3:0] S_DIVQ    = 4'd10;
    localparam logic [3:0] S_MULLO   = 4'd11;
    localparam logic [3:0] S_MULHI   = 4'd12;
    localparam logic [3:0] S_COMB    = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_W2;
                end
            end
            S_W2:
            begin
                cmd        = CMD_MUL_W2;
                state_next = S_S;
            end
            S_S:
            begin
                cmd        = CMD_MUL_S;
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                cmd        = CMD_DSUM;
                state_next = S_DIVP_LD;
            end
            S_DIVP_LD:
            begin
                if (status.d_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = CMD_DIV_P_START;
                    state_next = S_DIVP;
                end
            end
            S_DIVP:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_done)
                begin
                    state_next = status.apply_term ? S_DIVR_LD : S_FIN;
                end
            end
            S_DIVR_LD:
            begin
                cmd        = CMD_DIV_R_START;
                state_next = S_DIVR;
            end
            S_DIVR:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_done)
                begin
                    state_next = S_MULM;
                end
            end
            S_MULM:
            begin
                cmd        = CMD_MUL_M;
                state_next = S_DIVQ_LD;
            end
            S_DIVQ_LD:
            begin
                cmd        = CMD_DIV_Q_START;
                state_next = S_DIVQ;
            end
            S_DIVQ:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_done)
                begin
                    state_next = S_MULLO;
                end
            end
            S_MULLO:
            begin
                cmd        = CMD_MUL_LO;
                state_next = S_MULHI;
            end
            S_MULHI:
            begin
                cmd        = CMD_MUL_HI;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd        = CMD_COMB;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd        = CMD_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/wer_datapath.sv -----
// ----------------------------------------------------------------------------
// wer_datapath
// Shared multiplier, bit-serial restoring divider, penalty accumulator,
// neuron position counter and output register.
// ----------------------------------------------------------------------------
module wer_datapath
    import wer_pkg::*;
#(
    parameter int FAN_IN_MAX = FAN_IN_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output dp_status_t               status,
    input  logic                     enable,
    input  logic [DATA_W-1:0]        alpha,
    input  logic [W0_W-1:0]          scale_w0,
    input  logic [FAN_IN_W-1:0]      fan_in,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] gradient,
    input  logic                     last_weight,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] new_gradient,
    output logic [ACC_W-1:0]         penalty_sum,
    output logic                     is_last
);

    localparam int PW = $clog2(FAN_IN_MAX + 1);
    localparam int CW = (PW > FAN_IN_W) ? PW : FAN_IN_W;

    localparam logic [1:0] KIND_P = 2'd0;
    localparam logic [1:0] KIND_R = 2'd1;
    localparam logic [1:0] KIND_Q = 2'd2;

    localparam logic [5:0] ITER_P = 6'd17;
    localparam logic [5:0] ITER_R = 6'd33;
    localparam logic [5:0] ITER_Q = 6'd48;

    localparam logic [48:0] T_CLAMP = 49'h1_0000_0000;

    // Operand and intermediate registers
    logic [31:0]        wmag_reg;
    logic               wneg_reg;
    logic [31:0]        grad_reg;
    logic               last_reg;
    logic               bias_reg;
    logic               apply_reg;
    logic [62:0]        w2_reg;
    logic [61:0]        s_reg;
    logic [62:0]        d_reg;
    logic [64:0]        prod_reg;
    logic [55:0]        lo_reg;
    logic [16:0]        pterm_reg;
    logic [32:0]        rr_reg;
    logic [47:0]        q_reg;
    logic [32:0]        t_reg;

    // Divider
    logic [63:0]        rem_reg;
    logic [47:0]        xlo_reg;
    logic [47:0]        quo_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         kind_reg;

    // Control state
    logic [PW-1:0]      pos_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_grad_reg;
    logic [ACC_W-1:0]   out_pen_reg;
    logic               out_last_reg;

    // Combinational
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        mul_p;
    logic [63:0]        rsh;
    logic               ge;
    logic [47:0]        quo_new;
    logic [CW-1:0]      fi;
    logic               is_bias;
    logic [31:0]        wmag_in;
    logic [79:0]        full_prod;
    logic [48:0]        tq;
    logic signed [34:0] sum;
    logic [31:0]        sat_sum;
    logic [48:0]        acc_sum;
    logic [ACC_W-1:0]   acc_new;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd)
            CMD_MUL_W2:
            begin
                mul_a = {1'b0, wmag_reg};
                mul_b = wmag_reg;
            end
            CMD_MUL_S:
            begin
                mul_a = {2'b0, scale_w0};
                mul_b = {1'b0, scale_w0};
            end
            CMD_MUL_M:
            begin
                mul_a = rr_reg;
                mul_b = wmag_reg;
            end
            CMD_MUL_LO:
            begin
                mul_a = {9'b0, q_reg[23:0]};
                mul_b = alpha;
            end
            CMD_MUL_HI:
            begin
                mul_a = {9'b0, q_reg[47:24]};
                mul_b = alpha;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rsh     = {rem_reg[62:0], xlo_reg[47]};
    assign ge      = rsh >= {1'b0, d_reg};
    assign quo_new = {quo_reg[46:0], ge};

    assign fi      = (CW'(fan_in) > CW'(FAN_IN_MAX)) ? CW'(FAN_IN_MAX) : CW'(fan_in);
    assign is_bias = CW'(pos_reg) >= fi;
    assign wmag_in = weight[31] ? (~weight + 32'd1) : weight;

    assign full_prod = {prod_reg[55:0], 24'd0} + {24'd0, lo_reg};
    assign tq        = full_prod[79:31];

    assign sum = wneg_reg ? ($signed({{3{grad_reg[31]}}, grad_reg}) - $signed({2'b0, t_reg}))
                          : ($signed({{3{grad_reg[31]}}, grad_reg}) + $signed({2'b0, t_reg}));

    always_comb
    begin
        if (sum > 35'sd2147483647)
        begin
            sat_sum = 32'h7FFF_FFFF;
        end
        else if (sum < -35'sd2147483648)
        begin
            sat_sum = 32'h8000_0000;
        end
        else
        begin
            sat_sum = sum[31:0];
        end
    end

    assign acc_sum = {1'b0, acc_reg} + {32'd0, pterm_reg};
    assign acc_new = acc_sum[48] ? {ACC_W{1'b1}} : acc_sum[47:0];

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                wmag_reg  <= wmag_in;
                wneg_reg  <= weight[31];
                grad_reg  <= gradient;
                last_reg  <= last_weight;
                bias_reg  <= is_bias;
                apply_reg <= enable & ~is_bias;
                pterm_reg <= '0;
                t_reg     <= '0;
            end
            CMD_MUL_W2, CMD_MUL_M, CMD_MUL_LO:
            begin
                prod_reg <= mul_p;
            end
            CMD_MUL_S:
            begin
                prod_reg <= mul_p;
                w2_reg   <= prod_reg[62:0];
            end
            CMD_MUL_HI:
            begin
                prod_reg <= mul_p;
                lo_reg   <= prod_reg[55:0];
            end
            CMD_DSUM:
            begin
                s_reg <= prod_reg[61:0];
                d_reg <= w2_reg + {1'b0, prod_reg[61:0]};
            end
            CMD_DIV_P_START:
            begin
                rem_reg  <= {2'b0, w2_reg[62:1]};
                xlo_reg  <= {w2_reg[0], 47'd0};
                quo_reg  <= '0;
                cnt_reg  <= ITER_P;
                kind_reg <= KIND_P;
            end
            CMD_DIV_R_START:
            begin
                rem_reg  <= {3'b0, s_reg[61:1]};
                xlo_reg  <= {s_reg[0], 47'd0};
                quo_reg  <= '0;
                cnt_reg  <= ITER_R;
                kind_reg <= KIND_R;
            end
            CMD_DIV_Q_START:
            begin
                rem_reg  <= {32'd0, prod_reg[63:32]};
                xlo_reg  <= {prod_reg[31:0], 16'd0};
                quo_reg  <= '0;
                cnt_reg  <= ITER_Q;
                kind_reg <= KIND_Q;
            end
            CMD_DIV_STEP:
            begin
                rem_reg <= ge ? (rsh - {1'b0, d_reg}) : rsh;
                xlo_reg <= {xlo_reg[46:0], 1'b0};
                quo_reg <= quo_new;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    unique case (kind_reg)
                        KIND_P:  pterm_reg <= quo_new[16:0];
                        KIND_R:  rr_reg    <= quo_new[32:0];
                        KIND_Q:  q_reg     <= quo_new;
                        default: q_reg     <= quo_new;
                    endcase
                end
            end
            CMD_COMB:
            begin
                t_reg <= (tq > T_CLAMP) ? T_CLAMP[32:0] : tq[32:0];
            end
            CMD_FIN:
            begin
                out_grad_reg <= sat_sum;
                out_pen_reg  <= last_reg ? acc_new : '0;
                out_last_reg <= last_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // Control state: neuron position, penalty accumulator, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_FIN)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= last_reg ? '0 : acc_new;
                pos_reg       <= (bias_reg | last_reg) ? '0 : pos_reg + PW'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.d_zero     = (d_reg == '0);
    assign status.apply_term = apply_reg;
    assign status.div_done   = (cnt_reg == 6'd1);
    assign status.out_free   = ~out_valid_reg | out_ready;

    assign out_valid    = out_valid_reg;
    assign new_gradient = out_grad_reg;
    assign penalty_sum  = out_pen_reg;
    assign is_last      = out_last_reg;

endmodule

// ----- hw/rtl/weight_elimination_regularizer_top.sv -----
// ----------------------------------------------------------------------------
// weight_elimination_regularizer_top
// Weight-elimination gradient term and penalty accumulation, Q16.16.
// ----------------------------------------------------------------------------
// One request carries a weight, its gradient and a last flag; one result comes
// back per request. Weights arrive neuron by neuron: fan_in ordinary weights,
// then the bias. Ordinary weights get alpha*2*w*w0^2/(w0^2+w^2)^2 added to the
// gradient when enabled (saturated); biases pass through. Every element adds
// w^2/(w0^2+w^2) to a 48-bit Q32.16 penalty, reported on the last element and
// then cleared. The block works on one request at a time. When the term is not
// applied a request takes one 17-step division; when it is, 17 + 33 + 48
// division steps: the bit-serial restoring divider, one quotient bit per cycle,
// sets the rate. A zero denominator skips all divisions. The block is ready for
// the next request in the cycle after the result is loaded. The result register
// lets the next request enter while a result waits; a result still held when the
// next one finishes stalls the finish step. Configuration writes are to be made
// by the user only while the block is idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module weight_elimination_regularizer_top
    import wer_pkg::*;
#(
    parameter int FAN_IN_MAX = FAN_IN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wer_in_if.sink                in_ch,
    wer_out_if.source             out_ch
);

    // Configuration registers
    logic                enable_reg;
    logic [DATA_W-1:0]   alpha_reg;
    logic [W0_W-1:0]     scale_w0_reg;
    logic [FAN_IN_W-1:0] fan_in_reg;

    cmd_t       cmd;
    dp_status_t status;

    // Hold register values; write one on a config strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            alpha_reg    <= '0;
            scale_w0_reg <= W0_W'(65536);
            fan_in_reg   <= FAN_IN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:   enable_reg   <= cfg_data[0];
                REG_ALPHA:    alpha_reg    <= cfg_data;
                REG_SCALE_W0: scale_w0_reg <= cfg_data[W0_W-1:0];
                REG_FAN_IN:   fan_in_reg   <= cfg_data[FAN_IN_W-1:0];
                default:      enable_reg   <= enable_reg;
            endcase
        end
    end

    // Sequencer: accept a request, then advance the datapath step by step
    wer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: multiplier, divider, accumulator and result register
    wer_datapath #(
        .FAN_IN_MAX (FAN_IN_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .enable       (enable_reg),
        .alpha        (alpha_reg),
        .scale_w0     (scale_w0_reg),
        .fan_in       (fan_in_reg),
        .weight       (in_ch.weight),
        .gradient     (in_ch.gradient),
        .last_weight  (in_ch.last_weight),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .new_gradient (out_ch.new_gradient),
        .penalty_sum  (out_ch.penalty_sum),
        .is_last      (out_ch.is_last)
    );

    // A request in flight blocks the next one
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready
    ) else $error("request accepted while previous one in flight");

    // Penalty shows only with the last element
    a_penalty_only_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.is_last |-> out_ch.penalty_sum == '0
    ) else $error("penalty reported on a non-last element");

    // A new result needs a finished computation: ready returns with it
    a_result_ends_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> in_ch.ready
    ) else $error("result raised while sequencer busy");

endmodule

// ----- tb/sv/wer_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wer_tb_if
// Testbench view of the regularizer channels: the channels are the interfaces
// that the block declares, so this file only adds a typed result record used
// by the checker.
// ----------------------------------------------------------------------------
package wer_tb_pkg;
    import wer_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_gradient;
        logic [ACC_W-1:0]         penalty_sum;
        logic                     is_last;
    } wer_result_t;
endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weight-elimination regularizer.
// ----------------------------------------------------------------------------
// Drives weight requests through the input channel and compares every result
// with a bit-exact predictor of the gradient term and the running penalty.
// A directed table covers the extremes and the special cases first, then
// randomized layers run under several register settings. Both channels idle
// at random, with one long stretch of full throughput.
// ----------------------------------------------------------------------------
module tb;
    import wer_pkg::*;
    import wer_tb_pkg::*;

    localparam int        FAN_MAX    = FAN_IN_MAX_DEF;
    localparam logic [63:0] TERM_LIMIT = 64'h1_0000_0000;
    localparam logic [47:0] PEN_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam int        STALL_LIMIT = 20000;
    localparam int        RANDOM_ITEMS = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wer_in_if  in_ch ();
    wer_out_if out_ch ();

    weight_elimination_regularizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Predictor copy of the registers and the per-layer state
    logic        cur_enable;
    logic [31:0] cur_alpha;
    logic [30:0] cur_w0;
    logic [11:0] cur_fan_in;
    int unsigned neuron_pos;
    logic [47:0] penalty_acc;

    wer_result_t pending_results[$];
    int          mismatches;
    int          idle_cycles;
    bit          steady;      // no idling on either side while set
    bit          timed_out;

    // One entry of the directed table; chk marks a hand-typed expectation
    typedef struct {
        logic [31:0] w;
        logic [31:0] g;
        logic        last;
        bit          chk;
        logic [31:0] exp_grad;
        logic [47:0] exp_pen;
    } directed_row_t;

    always #6 clk = ~clk;

    // floor(num * 2^sh / den), saturated to 64 bits, done as a restoring divider
    function automatic logic [63:0] shifted_quotient(logic [63:0] num, int sh,
                                                     logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        bit          sat;
        logic        b;
        q   = '0;
        r   = '0;
        sat = 0;
        for (int i = 63 + sh; i >= 0; i--)
        begin
            b = (i >= sh) ? num[i - sh] : 1'b0;
            r = {r[63:0], b};
            if (q[63])
                sat = 1;
            q = q << 1;
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return sat ? '1 : q;
    endfunction

    // Work out one result and advance the predictor state
    function automatic wer_result_t regularize(logic [31:0] w, logic [31:0] g,
                                               logic last);
        wer_result_t  res;
        logic [63:0]  wmag, w2, s, d, pterm, t, rr, m, q;
        logic [127:0] prod;
        logic [48:0]  acc;
        longint       sum;
        bit           is_bias;
        int unsigned  fi;
        wmag = w[31] ? {32'd0, -w} : {32'd0, w};
        if (w == 32'h8000_0000)
            wmag = 64'h8000_0000;
        fi      = (cur_fan_in > FAN_MAX) ? FAN_MAX : cur_fan_in;
        is_bias = neuron_pos >= fi;
        w2      = wmag * wmag;
        s       = {33'd0, cur_w0} * {33'd0, cur_w0};
        d       = w2 + s;
        pterm   = 0;
        t       = 0;
        if (d != 0)
        begin
            pterm = shifted_quotient(w2, 16, d);
            if (!is_bias && cur_enable)
            begin
                rr   = shifted_quotient(s, 32, d);
                m    = wmag * rr;
                q    = shifted_quotient(m, 16, d);
                prod = {96'd0, cur_alpha} * {64'd0, q};
                if (prod[127:64] != 0)
                    t = TERM_LIMIT;
                else
                    t = prod[63:0] >> 31;
                if (t > TERM_LIMIT)
                    t = TERM_LIMIT;
            end
        end
        sum = w[31] ? longint'($signed(g)) - longint'(t)
                    : longint'($signed(g)) + longint'(t);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        acc = {1'b0, penalty_acc} + {1'b0, pterm[47:0]};
        if (pterm[63:48] != 0 || acc[48])
            acc = {1'b0, PEN_MAX};
        penalty_acc      = acc[47:0];
        res.new_gradient = sum[31:0];
        res.penalty_sum  = last ? penalty_acc : '0;
        res.is_last      = last;
        if (is_bias || last)
            neuron_pos = 0;
        else
            neuron_pos++;
        if (last)
            penalty_acc = '0;
        return res;
    endfunction

    // Write one register at a falling edge; mirror it into the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ENABLE:   cur_enable = value[0];
            REG_ALPHA:    cur_alpha  = value;
            REG_SCALE_W0: cur_w0     = value[30:0];
            REG_FAN_IN:   cur_fan_in = value[11:0];
            default: ;
        endcase
    endtask

    // Hold the request until accepted; random gaps before it unless steady
    task automatic send_request(logic [31:0] w, logic [31:0] g, logic last);
        do
            @(negedge clk);
        while (!steady && $urandom_range(99) < 37);
        in_ch.valid       <= 1'b1;
        in_ch.weight      <= w;
        in_ch.gradient    <= g;
        in_ch.last_weight <= last;
        pending_results.push_back(regularize(w, g, last));
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Same as send_request but the table row overrides the predictor
    task automatic send_directed(directed_row_t row);
        wer_result_t pred;
        send_request(row.w, row.g, row.last);
        if (row.chk)
        begin
            pred              = pending_results.pop_back();
            pred.new_gradient = row.exp_grad;
            pred.penalty_sum  = row.exp_pen;
            pending_results.push_back(pred);
        end
    endtask

    // Wait until every expected result is in, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic [31:0] random_weight();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1, 65536 * 4);
            2: return -$urandom_range(1, 65536 * 4);
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'd0;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    function automatic logic [31:0] random_gradient();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FF00 + $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
            default: return $urandom_range(65535 * 8) - 65536 * 4;
        endcase
    endfunction

    // Sink side: stall at random, check each accepted result at the rising edge
    always @(negedge clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        wer_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: grad %h pen %h last %b",
                             out_ch.new_gradient, out_ch.penalty_sum, out_ch.is_last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.new_gradient !== want.new_gradient ||
                    out_ch.penalty_sum !== want.penalty_sum ||
                    out_ch.is_last !== want.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: grad exp %h got %h, pen exp %h got %h, ",
                                  "last exp %b got %b"},
                                 want.new_gradient, out_ch.new_gradient,
                                 want.penalty_sum, out_ch.penalty_sum,
                                 want.is_last, out_ch.is_last);
                end
            end
        end
    end

    // Watchdog: count cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            timed_out = 1;
            $display("status: fail");
            $finish;
        end
    end

    // Random layers of random fan-in, mostly well-formed neurons
    task automatic random_layers(int count);
        int n;
        int fi;
        n  = 0;
        fi = (cur_fan_in == 0) ? 0 : cur_fan_in;
        while (n < count)
        begin
            int elems;
            elems = (fi + 1) * $urandom_range(1, 4) + ($urandom_range(9) == 0 ? 1 : 0);
            if (elems > 40)
                elems = $urandom_range(1, 40);
            for (int k = 0; k < elems && n < count; k++)
            begin
                send_request(random_weight(), random_gradient(),
                             k == elems - 1 || $urandom_range(49) == 0);
                n++;
            end
        end
    endtask

    directed_row_t directed_rows[$];

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_ENABLE;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.weight      = '0;
        in_ch.gradient    = '0;
        in_ch.last_weight = 1'b0;
        out_ch.ready      = 1'b0;
        mismatches        = 0;
        idle_cycles       = 0;
        steady            = 0;
        timed_out         = 0;
        cur_enable        = 1'b0;
        cur_alpha         = '0;
        cur_w0            = 31'd65536;
        cur_fan_in        = 12'd1;
        neuron_pos        = 0;
        penalty_acc       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset: disabled, w0 = 1.0. Weight 1.0 gives a penalty of 0.5;
        // weight 0 gives none; gradients pass through unchanged.
        directed_rows = '{
            '{32'h0001_0000, 32'h1234_5678, 1'b0, 1, 32'h1234_5678, 48'd0},
            '{32'h0000_0000, 32'h8000_0000, 1'b1, 1, 32'h8000_0000, 48'h8000},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, '0, '0},
            '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0, '0, '0},
            '{32'hFFFF_0000, 32'h0000_0000, 1'b1, 0, '0, '0}
        };
        foreach (directed_rows[i])
            send_directed(directed_rows[i]);
        drain();

        // Enabled with the largest alpha: terms clamp and gradients saturate; biases pass through
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_ALPHA, 32'hFFFF_FFFF);
        write_reg(REG_FAN_IN, 32'd2);
        directed_rows = '{
            '{32'h0001_0000, 32'h7FFF_0000, 1'b0, 1, 32'h7FFF_FFFF, 48'd0},
            '{32'hFFFF_0000, 32'h8000_FFFF, 1'b0, 1, 32'h8000_0000, 48'd0},
            '{32'h0001_0000, 32'h0000_1111, 1'b0, 1, 32'h0000_1111, 48'd0},
            '{32'h0000_0000, 32'h0000_0005, 1'b0, 0, '0, '0},
            '{32'h8000_0000, 32'h8000_0000, 1'b0, 0, '0, '0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0, '0, '0}
        };
        foreach (directed_rows[i])
            send_directed(directed_rows[i]);
        drain();

        // Zero w0 and zero weight: zero denominator; fan-in zero: all biases
        write_reg(REG_SCALE_W0, 32'd0);
        write_reg(REG_ALPHA, 32'h0001_0000);
        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0042, 1'b0, 1, 32'h0000_0042, 48'd0},
            '{32'h0000_0000, 32'h0000_0007, 1'b1, 1, 32'h0000_0007, 48'd0},
            '{32'h0003_0000, 32'h0000_0001, 1'b1, 0, '0, '0}
        };
        foreach (directed_rows[i])
            send_directed(directed_rows[i]);
        drain();
        write_reg(REG_SCALE_W0, 32'h7FFF_FFFF);
        write_reg(REG_FAN_IN, 32'd0);
        directed_rows = '{
            '{32'h0000_0001, 32'h0000_0009, 1'b0, 1, 32'h0000_0009, 48'd0},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 0, '0, '0}
        };
        foreach (directed_rows[i])
            send_directed(directed_rows[i]);
        drain();

        // Lower fan-in mid-neuron: the position runs past it
        write_reg(REG_SCALE_W0, 32'h0001_0000);
        write_reg(REG_FAN_IN, 32'd4);
        send_request(32'h0000_8000, 32'd0, 1'b0);
        send_request(32'h0000_8000, 32'd0, 1'b0);
        send_request(32'h0000_8000, 32'd0, 1'b0);
        drain();
        write_reg(REG_FAN_IN, 32'd1);
        send_request(32'h0000_8000, 32'd0, 1'b0);
        send_request(32'h0000_8000, 32'd0, 1'b1);
        drain();

        // Random phases under a spread of settings, one of them at full rate
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_ENABLE, (phase % 4 == 3) ? 32'd0 : 32'd1);
            case (phase % 4)
                0: write_reg(REG_ALPHA, $urandom_range(32'h0004_0000));
                1: write_reg(REG_ALPHA, 32'hFFFF_FFFF);
                2: write_reg(REG_ALPHA, $urandom());
                default: write_reg(REG_ALPHA, 32'd0);
            endcase
            case (phase % 3)
                0: write_reg(REG_SCALE_W0, $urandom_range(32'h0000_8000, 32'h0004_0000));
                1: write_reg(REG_SCALE_W0, $urandom() & 32'h7FFF_FFFF);
                default: write_reg(REG_SCALE_W0, $urandom_range(1) ? 32'h7FFF_FFFF : 32'd0);
            endcase
            if (phase == 6)
                write_reg(REG_FAN_IN, 32'd4095);
            else
                write_reg(REG_FAN_IN, $urandom_range(0, 7));
            steady = (phase == 4);
            random_layers(RANDOM_ITEMS / 8);
            steady = 0;
            drain();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/wer_pkg.sv
hw/rtl/wer_if.sv
hw/rtl/wer_ctrl.sv
hw/rtl/wer_datapath.sv
hw/rtl/weight_elimination_regularizer_top.sv
tb/sv/wer_tb_if.sv
tb/sv/tb.sv
